// ===== design/cbs_pkg.sv =====
`default_nettype none
package cbs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int COORD_W = 16;
  localparam int CLASS_W = 7;
  localparam int SCORE_W = 16;
  localparam int THR_W   = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

  // edge and overlap values in 2^-17 units, signed
  localparam int EDGE_W  = 20;
  localparam int OVL_W   = 18;
  localparam int AREA_W  = 2 * COORD_W;
  localparam int INTER_W = 2 * OVL_W;
  localparam int UNI_W   = AREA_W + 3;
  localparam int PROD_W  = UNI_W + THR_W;
  localparam int CMP_W   = PROD_W + 1;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic close;
    logic rd_i;
    logic cap_i;
    logic next_i;
    logic next_j;
    logic decide;
    logic rd_k;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_stop;
    logic match;
    logic k_last;
  } status_t;

endpackage
`default_nettype wire

// ===== design/cbs_ram.sv =====
`default_nettype none
module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/cbs_ctrl.sv =====
`default_nettype none
module cbs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            last_in,
  input  wire cbs_pkg::status_t st,
  output cbs_pkg::cmd_t        cmd,
  output logic                 busy
);
  import cbs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_OUTER = 11'b000_0000_0010,
    S_GETI  = 11'b000_0000_0100,
    S_INNER = 11'b000_0000_1000,
    S_C1    = 11'b000_0001_0000,
    S_C2    = 11'b000_0010_0000,
    S_C3    = 11'b000_0100_0000,
    S_C4    = 11'b000_1000_0000,
    S_DEC   = 11'b001_0000_0000,
    S_EMIT  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_in) begin
            cmd.close  = 1'b1;
            state_next = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        if (st.i_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = S_GETI;
        end
      end
      S_GETI: begin
        cmd.cap_i  = 1'b1;
        state_next = S_INNER;
      end
      S_INNER: begin
        if (st.j_stop) begin
          cmd.next_i = 1'b1;
          state_next = S_OUTER;
        end else begin
          state_next = S_C1;
        end
      end
      S_C1: begin
        if (!st.match) begin
          cmd.next_j = 1'b1;
          state_next = S_INNER;
        end else begin
          state_next = S_C2;
        end
      end
      S_C2: state_next = S_C3;
      S_C3: state_next = S_C4;
      S_C4: state_next = S_DEC;
      S_DEC: begin
        cmd.decide = 1'b1;
        cmd.next_j = 1'b1;
        state_next = S_INNER;
      end
      S_EMIT: begin
        cmd.rd_k = 1'b1;
        if (st.k_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/cbs_dp.sv =====
`default_nettype none
module cbs_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cbs_pkg::cmd_t            cmd,
  output cbs_pkg::status_t              st,
  input  wire logic                     cfg_we,
  input  wire logic [cbs_pkg::THR_W-1:0] cfg_data,
  input  wire cbs_pkg::entry_t          in_entry,
  output cbs_pkg::entry_t               out_entry,
  output logic                          kept,
  output logic                          overflowed,
  output logic                          result_valid,
  output logic                          last_out
);
  import cbs_pkg::*;

  logic [THR_W-1:0]  thr;
  logic [CNT_W-1:0]  cnt, i, j, k;
  logic              ovf;
  logic              full;
  entry_t            ent_i;
  logic              alive_i;
  logic [AREA_W-1:0] area_i, area_j;
  logic signed [EDGE_W-1:0] ow, oh;
  logic [INTER_W-1:0] inter;
  logic [UNI_W-1:0]   sum, uni;
  logic [PROD_W-1:0]  prod;
  logic               sup;

  entry_t            rd_entry;
  logic [0:0]        rd_alive;
  logic [ADDR_W-1:0] raddr;
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [0:0]        a_wdata;

  assign full = (cnt == CNT_W'(MAX_ENTRIES));

  // j stays on the read port so entry j is held through the compare
  always_comb begin
    if (cmd.rd_i) begin
      raddr = i[ADDR_W-1:0];
    end else if (cmd.rd_k) begin
      raddr = k[ADDR_W-1:0];
    end else begin
      raddr = j[ADDR_W-1:0];
    end
  end

  always_comb begin
    a_we    = 1'b0;
    a_waddr = cnt[ADDR_W-1:0];
    a_wdata = 1'b0;
    if (cmd.load) begin
      a_we    = !full;
      a_wdata = (in_entry.score != '0);
    end else if (cmd.decide && sup) begin
      a_we = 1'b1;
      if (ent_i.score < rd_entry.score) begin
        a_waddr = i[ADDR_W-1:0];
      end else begin
        a_waddr = j[ADDR_W-1:0];
      end
    end
  end

  cbs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (in_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  cbs_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_alive_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (rd_alive)
  );

  // box edges in 2^-17 units
  function automatic logic signed [EDGE_W-1:0] lo_edge(logic [COORD_W-1:0] c,
                                                       logic [COORD_W-1:0] s);
    return $signed({3'b000, c, 1'b0}) - $signed({4'b0000, s});
  endfunction

  function automatic logic signed [EDGE_W-1:0] hi_edge(logic [COORD_W-1:0] c,
                                                       logic [COORD_W-1:0] s);
    return $signed({3'b000, c, 1'b0}) + $signed({4'b0000, s});
  endfunction

  function automatic logic signed [EDGE_W-1:0] overlap(
      logic [COORD_W-1:0] c1, logic [COORD_W-1:0] s1,
      logic [COORD_W-1:0] c2, logic [COORD_W-1:0] s2);
    logic signed [EDGE_W-1:0] l1, l2, r1, r2, lft, rgt;
    l1  = lo_edge(c1, s1);
    l2  = lo_edge(c2, s2);
    r1  = hi_edge(c1, s1);
    r2  = hi_edge(c2, s2);
    lft = (l1 > l2) ? l1 : l2;
    rgt = (r1 < r2) ? r1 : r2;
    return rgt - lft;
  endfunction

  assign sup = {inter, 16'h0000} > {1'b0, prod};

  always_ff @(posedge clk) begin
    // compare pipeline, free running on the held read data
    ow     <= overlap(ent_i.center_x, ent_i.box_width, rd_entry.center_x,
                      rd_entry.box_width);
    oh     <= overlap(ent_i.center_y, ent_i.box_height, rd_entry.center_y,
                      rd_entry.box_height);
    area_j <= rd_entry.box_width * rd_entry.box_height;
    if (!ow[EDGE_W-1] && !oh[EDGE_W-1]) begin
      inter <= ow[OVL_W-1:0] * oh[OVL_W-1:0];
    end else begin
      inter <= '0;
    end
    sum  <= {1'b0, area_i, 2'b00} + {1'b0, area_j, 2'b00};
    uni  <= sum - inter[UNI_W-1:0];
    prod <= thr * uni;
    if (cmd.cap_i) begin
      ent_i  <= rd_entry;
      area_i <= rd_entry.box_width * rd_entry.box_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr          <= THR_RESET;
      cnt          <= '0;
      ovf          <= 1'b0;
      i            <= '0;
      j            <= '0;
      k            <= '0;
      alive_i      <= 1'b0;
      result_valid <= 1'b0;
      last_out     <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.close) begin
        i <= '0;
      end
      if (cmd.next_i) begin
        i <= i + 1'b1;
      end
      if (cmd.cap_i) begin
        alive_i <= rd_alive[0];
        j       <= i + 1'b1;
      end
      if (cmd.next_j) begin
        j <= j + 1'b1;
      end
      if (cmd.decide && sup && (ent_i.score < rd_entry.score)) begin
        alive_i <= 1'b0;
      end
      if (cmd.rd_k) begin
        k <= k + 1'b1;
      end
      result_valid <= cmd.rd_k;
      last_out     <= cmd.rd_k && st.k_last;
      if (cmd.finish) begin
        cnt <= '0;
        ovf <= 1'b0;
        k   <= '0;
      end
    end
  end

  assign st.i_end  = (i >= cnt);
  assign st.j_stop = !alive_i || (j >= cnt);
  assign st.match  = rd_alive[0] && (rd_entry.class_id == ent_i.class_id);
  assign st.k_last = (k == cnt - 1'b1);

  assign out_entry  = rd_entry;
  assign kept       = rd_alive[0];
  assign overflowed = ovf;

endmodule
`default_nettype wire

// ===== design/classwise_box_suppression.sv =====
// Channel   Ports                                      Handshake
// config    cfg_we, cfg_data                           write when cfg_we high
// input     start, center_x .. score, last_in          taken when start & !busy
// result    result_valid, out_center_x .. last_out     one cycle per strobe
//
// Loading an item other than the closing one leaves busy low. After the closing
// item, suppression runs on one compare unit: each outer entry is read, captured
// and ends its scan; a skipped pair is read and tested; a compared pair goes
// through read, overlap, intersection, union, product and decide. Once the end
// is seen, the N stored entries are emitted one per cycle, the last one in the
// final busy cycle. Reset is synchronous; the stores hold no reset.
// Results cannot be stalled.
`default_nettype none
module classwise_box_suppression (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cbs_pkg::THR_W-1:0]   cfg_data,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cbs_pkg::COORD_W-1:0] center_x,
  input  wire logic [cbs_pkg::COORD_W-1:0] center_y,
  input  wire logic [cbs_pkg::COORD_W-1:0] box_width,
  input  wire logic [cbs_pkg::COORD_W-1:0] box_height,
  input  wire logic [cbs_pkg::CLASS_W-1:0] class_id,
  input  wire logic [cbs_pkg::SCORE_W-1:0] score,
  input  wire logic                        last_in,
  output logic                             result_valid,
  output logic [cbs_pkg::COORD_W-1:0]      out_center_x,
  output logic [cbs_pkg::COORD_W-1:0]      out_center_y,
  output logic [cbs_pkg::COORD_W-1:0]      out_width,
  output logic [cbs_pkg::COORD_W-1:0]      out_height,
  output logic [cbs_pkg::CLASS_W-1:0]      out_class,
  output logic [cbs_pkg::SCORE_W-1:0]      out_score,
  output logic                             kept,
  output logic                             overflowed,
  output logic                             last_out
);
  import cbs_pkg::*;

  cmd_t    cmd;
  status_t st;
  entry_t  in_entry, out_entry;

  assign in_entry.center_x   = center_x;
  assign in_entry.center_y   = center_y;
  assign in_entry.box_width  = box_width;
  assign in_entry.box_height = box_height;
  assign in_entry.class_id   = class_id;
  assign in_entry.score      = score;

  cbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (last_in),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  cbs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_entry     (in_entry),
    .out_entry    (out_entry),
    .kept         (kept),
    .overflowed   (overflowed),
    .result_valid (result_valid),
    .last_out     (last_out)
  );

  assign out_center_x = out_entry.center_x;
  assign out_center_y = out_entry.center_y;
  assign out_width    = out_entry.box_width;
  assign out_height   = out_entry.box_height;
  assign out_class    = out_entry.class_id;
  assign out_score    = out_entry.score;

endmodule
`default_nettype wire

// ===== sim/classwise_box_suppression_chk.sv =====
`timescale 1ns / 1ps
module classwise_box_suppression_chk (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cbs_pkg::THR_W-1:0]   cfg_data,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [cbs_pkg::COORD_W-1:0] center_x,
  input  wire logic [cbs_pkg::COORD_W-1:0] center_y,
  input  wire logic [cbs_pkg::COORD_W-1:0] box_width,
  input  wire logic [cbs_pkg::COORD_W-1:0] box_height,
  input  wire logic [cbs_pkg::CLASS_W-1:0] class_id,
  input  wire logic [cbs_pkg::SCORE_W-1:0] score,
  input  wire logic                        last_in,
  input  wire logic                        result_valid,
  input  wire logic [cbs_pkg::COORD_W-1:0] out_center_x,
  input  wire logic [cbs_pkg::COORD_W-1:0] out_center_y,
  input  wire logic [cbs_pkg::COORD_W-1:0] out_width,
  input  wire logic [cbs_pkg::COORD_W-1:0] out_height,
  input  wire logic [cbs_pkg::CLASS_W-1:0] out_class,
  input  wire logic [cbs_pkg::SCORE_W-1:0] out_score,
  input  wire logic                        kept,
  input  wire logic                        overflowed,
  input  wire logic                        last_out,
  output int                               errors,
  output int                               pending
);
  import cbs_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] sc;
    logic               keep;
    logic               ovf;
    logic               last;
  } det_t;

  det_t             stored_dets[MAX_ENTRIES];
  det_t             expected_dets[$];
  int               n_stored;
  logic             dropped;
  logic [THR_W-1:0] iou_thr;

  function automatic longint axis_overlap(longint c1, longint s1, longint c2, longint s2);
    longint lo;
    longint hi;
    lo = (2 * c1 - s1) > (2 * c2 - s2) ? (2 * c1 - s1) : (2 * c2 - s2);
    hi = (2 * c1 + s1) < (2 * c2 + s2) ? (2 * c1 + s1) : (2 * c2 + s2);
    return hi - lo;
  endfunction

  function automatic bit iou_exceeds(det_t a, det_t b);
    longint ow;
    longint oh;
    longint inter;
    longint uni;
    ow = axis_overlap(longint'(a.cx), longint'(a.w), longint'(b.cx), longint'(b.w));
    oh = axis_overlap(longint'(a.cy), longint'(a.h), longint'(b.cy), longint'(b.h));
    inter = (ow >= 0 && oh >= 0) ? ow * oh : 0;
    uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
    return inter * 65536 > longint'(iou_thr) * uni;
  endfunction

  task automatic close_set();
    for (int i = 0; i < n_stored; i++) begin
      for (int j = i + 1; j < n_stored && stored_dets[i].keep; j++) begin
        if (!stored_dets[j].keep || stored_dets[i].cls != stored_dets[j].cls) continue;
        if (iou_exceeds(stored_dets[i], stored_dets[j])) begin
          if (stored_dets[i].sc < stored_dets[j].sc) stored_dets[i].keep = 1'b0;
          else stored_dets[j].keep = 1'b0;
        end
      end
    end
    for (int k = 0; k < n_stored; k++) begin
      stored_dets[k].ovf = dropped;
      stored_dets[k].last = (k == n_stored - 1);
      expected_dets = {expected_dets, stored_dets[k]};
    end
    n_stored = 0;
    dropped = 1'b0;
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    det_t d;
    if (rst) begin
      n_stored = 0;
      dropped = 1'b0;
      iou_thr = THR_RESET;
      expected_dets.delete();
      errors = 0;
    end else begin
      if (cfg_we) iou_thr = cfg_data;
      if (start && !busy) begin
        if (n_stored < MAX_ENTRIES) begin
          d.cx = center_x;
          d.cy = center_y;
          d.w = box_width;
          d.h = box_height;
          d.cls = class_id;
          d.sc = score;
          d.keep = (score != 0);
          d.ovf = 1'b0;
          d.last = 1'b0;
          stored_dets[n_stored] = d;
          n_stored++;
        end else begin
          dropped = 1'b1;
        end
        if (last_in) close_set();
      end
      if (result_valid) begin
        if (expected_dets.size() == 0) begin
          $error("result with no item expected");
          errors++;
        end else begin
          d = expected_dets.pop_front();
          check_field("out_center_x", d.cx, out_center_x);
          check_field("out_center_y", d.cy, out_center_y);
          check_field("out_width", d.w, out_width);
          check_field("out_height", d.h, out_height);
          check_field("out_class", d.cls, out_class);
          check_field("out_score", d.sc, out_score);
          check_field("kept", d.keep, kept);
          check_field("overflowed", d.ovf, overflowed);
          check_field("last_out", d.last, last_out);
        end
      end
    end
    pending = expected_dets.size();
  end
endmodule

// ===== sim/classwise_box_suppression_tb.sv =====
`timescale 1ns / 1ps
module classwise_box_suppression_tb;
  import cbs_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [THR_W-1:0]   cfg_data;
  logic               start;
  logic               busy;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COORD_W-1:0] box_width;
  logic [COORD_W-1:0] box_height;
  logic [CLASS_W-1:0] class_id;
  logic [SCORE_W-1:0] score;
  logic               last_in;
  logic               result_valid;
  logic [COORD_W-1:0] out_center_x;
  logic [COORD_W-1:0] out_center_y;
  logic [COORD_W-1:0] out_width;
  logic [COORD_W-1:0] out_height;
  logic [CLASS_W-1:0] out_class;
  logic [SCORE_W-1:0] out_score;
  logic               kept;
  logic               overflowed;
  logic               last_out;
  int                 errors;
  int                 pending;
  int                 items_sent;
  int                 burst_left;

  classwise_box_suppression dut (.*);
  classwise_box_suppression_chk chk (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #2000000;
    $display("classwise_box_suppression test failed");
    $finish;
  end

  task automatic send_det(int cx, int cy, int w, int h, int cls, int sc, bit last);
    logic b;
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    center_x = COORD_W'(cx);
    center_y = COORD_W'(cy);
    box_width = COORD_W'(w);
    box_height = COORD_W'(h);
    class_id = CLASS_W'(cls);
    score = SCORE_W'(sc);
    last_in = last;
    start = 1'b1;
    do begin
      b = busy;
      @(posedge clk);
      if (b) @(negedge clk);
    end while (b);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_threshold(int v);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = THR_W'(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // clustered boxes in a couple of classes so that suppression really fires
  task automatic rand_set(int n);
    int cx0;
    int cy0;
    int cls0;
    int sc;
    cx0 = $urandom_range(2000, 63000);
    cy0 = $urandom_range(2000, 63000);
    cls0 = $urandom_range(0, 126);
    sc = $urandom_range(1, 65535);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_det($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 127), $urandom_range(0, 65535), k == n - 1);
      end else begin
        case ($urandom_range(0, 9))
          0: sc = 0;
          1, 2: ;
          default: sc = $urandom_range(1, 65535);
        endcase
        send_det((cx0 + $urandom_range(0, 2000) - 1000) & 16'hffff,
                 (cy0 + $urandom_range(0, 2000) - 1000) & 16'hffff,
                 $urandom_range(1000, 12000), $urandom_range(1000, 12000),
                 cls0 + $urandom_range(0, 1), sc, k == n - 1);
      end
    end
  endtask

  initial begin
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    center_x = '0;
    center_y = '0;
    box_width = '0;
    box_height = '0;
    class_id = '0;
    score = '0;
    last_in = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_det(0, 0, 0, 0, 0, 0, 0);
    send_det(65535, 65535, 65535, 65535, 127, 65535, 0);
    send_det(65535, 65535, 65535, 65535, 127, 65535, 0);
    send_det(100, 100, 0, 0, 5, 7, 0);
    send_det(100, 100, 0, 0, 5, 9, 0);
    send_det(30000, 30000, 8000, 8000, 3, 100, 0);
    send_det(30000, 30000, 8000, 8000, 3, 200, 0);
    send_det(30500, 30000, 8000, 8000, 3, 150, 0);
    send_det(60000, 5000, 2000, 2000, 3, 300, 0);
    send_det(30000, 30000, 8000, 8000, 4, 50, 0);
    send_det(0, 0, 65535, 65535, 3, 1, 1);
    send_det(40000, 20000, 5000, 5000, 9, 42, 1);
    write_threshold(0);
    rand_set(64);
    write_threshold(65535);
    send_det(1000, 1000, 500, 500, 2, 10, 0);
    send_det(1000, 1000, 500, 500, 2, 10, 1);
    rand_set(65);

    while (items_sent < 320) begin
      r = $urandom_range(0, 4);
      if (r == 0) write_threshold(0);
      else if (r == 1) write_threshold($urandom_range(0, 65535));
      else if (r == 2) write_threshold(THR_RESET);
      r = $urandom_range(0, 19);
      if (r == 0) rand_set(64);
      else if (r == 1) rand_set($urandom_range(65, 68));
      else rand_set($urandom_range(1, 10));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("classwise_box_suppression test passed");
    end else begin
      $display("classwise_box_suppression test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/cbs_pkg.sv
design/cbs_ram.sv
design/cbs_ctrl.sv
design/cbs_dp.sv
design/classwise_box_suppression.sv
sim/classwise_box_suppression_chk.sv
sim/classwise_box_suppression_tb.sv
